FILE: src/hcd_pkg.sv
`timescale 1ns / 1ps
// Shared types, register map, reset values and Sobel tap tables of the corner detector.
package hcd_pkg;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_NMS_WINDOW = 7;

    localparam int PAW = 4;
    localparam int PDW = 32;

    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_K_COEF       = 2'd2;
    localparam logic [1:0] REG_THRESHOLD    = 2'd3;

    localparam logic [11:0] RST_FRAME_WIDTH  = 12'd1280;
    localparam logic [11:0] RST_FRAME_HEIGHT = 12'd720;
    localparam logic [15:0] RST_K_COEF       = 16'd2621;
    localparam logic [31:0] RST_THRESHOLD    = 32'd2113930012;

    localparam int PW        = 22;
    localparam int GRAD_TAPS = 7;

    localparam logic [2:0] W_ZERO = 3'd0;
    localparam logic [2:0] W_POS1 = 3'd1;
    localparam logic [2:0] W_POS2 = 3'd2;
    localparam logic [2:0] W_NEG1 = 3'd3;
    localparam logic [2:0] W_NEG2 = 3'd4;

    typedef struct packed {
        logic [7:0] pixel;
        logic       frame_start;
    } t_pixel_in;

    typedef struct packed {
        logic [10:0] row;
        logic [10:0] column;
        logic        is_corner;
    } t_result;

    typedef struct packed {
        logic [PW-1:0]        pxx;
        logic [PW-1:0]        pyy;
        logic signed [PW-1:0] pxy;
    } t_prod;

    // Rows above the newest row for each stored tap of the 3x3 Sobel window.
    function automatic logic [1:0] grad_row_off(input logic [2:0] tap);
        logic [1:0] off;
        unique case (tap)
            3'd0:    off = 2'd2;
            3'd1:    off = 2'd1;
            3'd2:    off = 2'd2;
            3'd3:    off = 2'd1;
            3'd4:    off = 2'd0;
            3'd5:    off = 2'd0;
            3'd6:    off = 2'd2;
            default: off = 2'd0;
        endcase
        return off;
    endfunction

    function automatic logic [1:0] grad_col_off(input logic [2:0] tap);
        logic [1:0] off;
        unique case (tap)
            3'd0:    off = 2'd0;
            3'd1:    off = 2'd0;
            3'd2:    off = 2'd2;
            3'd3:    off = 2'd2;
            3'd4:    off = 2'd2;
            3'd5:    off = 2'd1;
            3'd6:    off = 2'd1;
            default: off = 2'd0;
        endcase
        return off;
    endfunction

    function automatic logic [2:0] grad_wx(input logic [2:0] tap);
        logic [2:0] w;
        unique case (tap)
            3'd0:    w = W_POS1;
            3'd1:    w = W_POS2;
            3'd2:    w = W_NEG1;
            3'd3:    w = W_NEG2;
            3'd4:    w = W_NEG1;
            default: w = W_ZERO;
        endcase
        return w;
    endfunction

    function automatic logic [2:0] grad_wy(input logic [2:0] tap);
        logic [2:0] w;
        unique case (tap)
            3'd0:    w = W_NEG1;
            3'd2:    w = W_NEG1;
            3'd4:    w = W_POS1;
            3'd5:    w = W_POS2;
            3'd6:    w = W_NEG2;
            default: w = W_ZERO;
        endcase
        return w;
    endfunction

    function automatic logic signed [11:0] apply_weight(input logic [7:0] p,
                                                        input logic [2:0] w);
        logic signed [11:0] v;
        logic signed [11:0] res;
        v = $signed({4'b0, p});
        unique case (w)
            W_POS1:  res = v;
            W_POS2:  res = v + v;
            W_NEG1:  res = -v;
            W_NEG2:  res = -(v + v);
            default: res = '0;
        endcase
        return res;
    endfunction

endpackage

FILE: src/hcd_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and one registered read port.
module hcd_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/harris_corner_detector_unit.sv
`timescale 1ns / 1ps
// Harris corner detector: takes one grey pixel per beat in raster order and, for every pixel
// lying at least 2 + NMS_WINDOW/2 from each edge, returns one beat with its row, column and
// a corner flag (no larger response in its NMS_WINDOW square window and response above the
// threshold). Pixels are handled one at a time. A pixel in the first two rows or columns is
// only stored; others also yield gradient products, and those further in also a response. A pixel that
// yields a result also runs the suppression window, which walks the response line store
// through its single read port one entry per cycle. A stalled result beat holds the block
// until it is taken. The line stores hold undefined data after reset and need no clearing.
// Registers must be written over the APB port only while the block is idle; the block itself
// does not enforce this.
module harris_corner_detector_unit #(
    parameter int MAX_WIDTH  = hcd_pkg::DEF_MAX_WIDTH,
    parameter int NMS_WINDOW = hcd_pkg::DEF_NMS_WINDOW
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  hcd_pkg::t_pixel_in       i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output hcd_pkg::t_result         o_out_data,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [hcd_pkg::PAW-1:0]  paddr,
    input  logic [hcd_pkg::PDW-1:0]  pwdata,
    output logic [hcd_pkg::PDW-1:0]  prdata,
    output logic                     pready
);

    import hcd_pkg::*;

    localparam int CW        = $clog2(MAX_WIDTH);
    localparam int WW        = CW + 1;
    localparam int HALF      = NMS_WINDOW / 2;
    localparam int MARGIN    = 2 + HALF;
    localparam int NMS_REACH = 2 + 2 * HALF;
    localparam int SW        = $clog2(NMS_WINDOW);
    localparam int LW        = (SW > 3) ? SW : 3;
    localparam int LN_DEPTH  = 3 * MAX_WIDTH;
    localparam int RS_DEPTH  = NMS_WINDOW * MAX_WIDTH;
    localparam int XAW       = $clog2(LN_DEPTH);
    localparam int RAW       = $clog2(RS_DEPTH);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PIX  = 4'd1;
    localparam logic [3:0] S_GRD  = 4'd2;
    localparam logic [3:0] S_MUL  = 4'd3;
    localparam logic [3:0] S_PWR  = 4'd4;
    localparam logic [3:0] S_BOX  = 4'd5;
    localparam logic [3:0] S_RSP1 = 4'd6;
    localparam logic [3:0] S_RSP2 = 4'd7;
    localparam logic [3:0] S_RSP3 = 4'd8;
    localparam logic [3:0] S_RSP4 = 4'd9;
    localparam logic [3:0] S_RSP5 = 4'd10;
    localparam logic [3:0] S_CEN  = 4'd11;
    localparam logic [3:0] S_CENW = 4'd12;
    localparam logic [3:0] S_NMS  = 4'd13;
    localparam logic [3:0] S_OUT  = 4'd14;

    // Row slot that lies off rows above the given slot, in a ring of modulus rows.
    function automatic logic [7:0] slot_back(input logic [7:0] slot, input logic [7:0] off,
                                             input logic [7:0] modulus);
        logic [7:0] v;
        v = slot + modulus + modulus - off;
        if (v >= modulus) v = v - modulus;
        if (v >= modulus) v = v - modulus;
        return v;
    endfunction

    function automatic logic [XAW-1:0] line_addr(input logic [7:0] slot,
                                                 input logic [CW-1:0] col);
        return XAW'(slot) * XAW'(MAX_WIDTH) + XAW'(col);
    endfunction

    function automatic logic [RAW-1:0] resp_addr(input logic [7:0] slot,
                                                 input logic [CW-1:0] col);
        return RAW'(slot) * RAW'(MAX_WIDTH) + RAW'(col);
    endfunction

    // Configuration
    logic [11:0] r_frame_width;
    logic [11:0] r_frame_height;
    logic [15:0] r_k;
    logic [31:0] r_thr;
    logic        cfg_wr;

    // Control
    logic [3:0]    r_state;
    logic [3:0]    n_state;
    logic [10:0]   r_row_cnt;
    logic [CW-1:0] r_col_cnt;
    logic [1:0]    r_cnt_s3;
    logic [SW-1:0] r_cnt_s7;
    logic [LW-1:0] r_i;
    logic [LW-1:0] r_j;
    logic [LW-1:0] i_last;
    logic [LW-1:0] j_last;
    logic          r_iss_done;
    logic          r_dv;
    logic          r_out_valid;
    logic          in_accept;
    logic          in_loop;
    logic          loop_end;
    logic          out_load;
    logic          grad_ok;
    logic          box_ok;
    logic          nms_ok;

    // Position of the pixel in hand
    logic [10:0]   r_row;
    logic [CW-1:0] r_col;
    logic [1:0]    r_s3;
    logic [SW-1:0] r_s7;
    logic [7:0]    r_pix;

    logic [WW-1:0] eff_w;
    logic [11:0]   eff_h;
    logic [CW-1:0] st_col;
    logic [11:0]   st_row;
    logic [1:0]    st_s3;
    logic [SW-1:0] st_s7;
    logic [WW-1:0] en_col;
    logic [11:0]   en_row;
    logic [1:0]    en_s3;
    logic [SW-1:0] en_s7;

    // Datapath
    logic [2:0]          r_tag;
    logic signed [11:0]  r_gx;
    logic signed [11:0]  r_gy;
    logic signed [23:0]  mxx;
    logic signed [23:0]  myy;
    logic signed [23:0]  mxy;
    t_prod               r_prod;
    t_prod               box_d;
    logic signed [25:0]  r_sxx;
    logic signed [25:0]  r_syy;
    logic signed [25:0]  r_sxy;
    logic signed [25:0]  r_tr;
    logic signed [51:0]  r_m1;
    logic signed [51:0]  r_m2;
    logic signed [51:0]  tr_sq;
    logic [49:0]         r_t2;
    logic signed [63:0]  r_det;
    logic [33:0]         r_khi;
    logic [47:0]         r_klo;
    logic [50:0]         r_kt;
    logic signed [63:0]  r_centre;
    logic                r_is_max;
    t_result             r_out_data;

    // Memory ports
    logic [XAW-1:0] pix_wr_addr;
    logic [XAW-1:0] pix_rd_addr;
    logic [7:0]     pix_rd_data;
    logic [XAW-1:0] prod_wr_addr;
    logic [XAW-1:0] prod_rd_addr;
    logic [3*PW-1:0] prod_rd_data;
    logic [RAW-1:0] resp_wr_addr;
    logic [RAW-1:0] resp_rd_addr;
    logic [63:0]    resp_wr_data;
    logic [63:0]    resp_rd_data;

    assign cfg_wr     = psel && penable && pwrite && pready;
    assign pready     = 1'b1;
    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        unique case (paddr[3:2])
            REG_FRAME_WIDTH:  prdata = 32'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = 32'(r_frame_height);
            REG_K_COEF:       prdata = 32'(r_k);
            REG_THRESHOLD:    prdata = r_thr;
            default:          prdata = '0;
        endcase
    end

    always_comb begin
        if (r_frame_width == '0) begin
            eff_w = WW'(1);
        end else if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            eff_h = 12'd1;
        end else if (r_frame_height > 12'd2048) begin
            eff_h = 12'd2048;
        end else begin
            eff_h = r_frame_height;
        end
    end

    // Position of an arriving pixel, after a frame start or any wrap left pending by a register change.
    always_comb begin
        st_col = r_col_cnt;
        st_row = {1'b0, r_row_cnt};
        st_s3  = r_cnt_s3;
        st_s7  = r_cnt_s7;
        if (i_in_data.frame_start) begin
            st_col = '0;
            st_row = '0;
            st_s3  = '0;
            st_s7  = '0;
        end
        if ({1'b0, st_col} >= eff_w) begin
            st_col = '0;
            st_row = st_row + 12'd1;
            st_s3  = (st_s3 == 2'd2) ? 2'd0 : st_s3 + 2'd1;
            st_s7  = (st_s7 == SW'(NMS_WINDOW - 1)) ? '0 : st_s7 + SW'(1);
        end
        if (st_row >= eff_h) begin
            st_row = '0;
            st_s3  = '0;
            st_s7  = '0;
        end
    end

    // Position of the next pixel once the current one is taken.
    always_comb begin
        en_col = {1'b0, r_col} + WW'(1);
        en_row = {1'b0, r_row};
        en_s3  = r_s3;
        en_s7  = r_s7;
        if (en_col >= eff_w) begin
            en_col = '0;
            en_row = en_row + 12'd1;
            en_s3  = (en_s3 == 2'd2) ? 2'd0 : en_s3 + 2'd1;
            en_s7  = (en_s7 == SW'(NMS_WINDOW - 1)) ? '0 : en_s7 + SW'(1);
            if (en_row >= eff_h) begin
                en_row = '0;
                en_s3  = '0;
                en_s7  = '0;
            end
        end
    end

    assign grad_ok = (r_row >= 11'd2) && (32'(r_col) >= 2);
    assign box_ok  = (r_row >= 11'd4) && (32'(r_col) >= 4);
    assign nms_ok  = (32'(r_row) >= 2 * MARGIN) && (32'(r_col) >= 2 * MARGIN);

    assign in_loop  = (r_state == S_GRD) || (r_state == S_BOX) || (r_state == S_NMS);
    assign loop_end = r_iss_done && !r_dv;
    assign out_load = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    always_comb begin
        unique case (r_state)
            S_GRD: begin
                i_last = '0;
                j_last = LW'(GRAD_TAPS - 1);
            end
            S_BOX: begin
                i_last = LW'(2);
                j_last = LW'(2);
            end
            default: begin
                i_last = LW'(NMS_WINDOW - 1);
                j_last = LW'(NMS_WINDOW - 1);
            end
        endcase
    end

    always_comb begin
        unique case (r_state)
            S_IDLE:  n_state = in_accept ? S_PIX : S_IDLE;
            S_PIX:   n_state = grad_ok ? S_GRD : S_IDLE;
            S_GRD:   n_state = loop_end ? S_MUL : S_GRD;
            S_MUL:   n_state = S_PWR;
            S_PWR:   n_state = box_ok ? S_BOX : S_IDLE;
            S_BOX:   n_state = loop_end ? S_RSP1 : S_BOX;
            S_RSP1:  n_state = S_RSP2;
            S_RSP2:  n_state = S_RSP3;
            S_RSP3:  n_state = S_RSP4;
            S_RSP4:  n_state = S_RSP5;
            S_RSP5:  n_state = nms_ok ? S_CEN : S_IDLE;
            S_CEN:   n_state = S_CENW;
            S_CENW:  n_state = S_NMS;
            S_NMS:   n_state = loop_end ? S_OUT : S_NMS;
            S_OUT:   n_state = out_load ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    // Store addresses
    always_comb begin
        pix_wr_addr  = line_addr(8'(r_s3), r_col);
        pix_rd_addr  = line_addr(slot_back(8'(r_s3), 8'(grad_row_off(r_j[2:0])), 8'd3),
                                 r_col - CW'(grad_col_off(r_j[2:0])));
        prod_wr_addr = line_addr(slot_back(8'(r_s3), 8'd1, 8'd3), r_col - CW'(1));
        prod_rd_addr = line_addr(slot_back(8'(r_s3), 8'(r_i) + 8'd1, 8'd3),
                                 r_col - CW'(r_j) - CW'(1));
        resp_wr_addr = resp_addr(slot_back(8'(r_s7), 8'd2, 8'(NMS_WINDOW)), r_col - CW'(2));
        if (r_state == S_CEN) begin
            resp_rd_addr = resp_addr(slot_back(8'(r_s7), 8'(MARGIN), 8'(NMS_WINDOW)),
                                     r_col - CW'(MARGIN));
        end else begin
            resp_rd_addr = resp_addr(slot_back(8'(r_s7), 8'(NMS_REACH) - 8'(r_i),
                                               8'(NMS_WINDOW)),
                                     r_col - CW'(NMS_REACH) + CW'(r_j));
        end
    end

    assign resp_wr_data = r_det - $signed(64'(r_kt));

    hcd_ram #(.WIDTH(8), .DEPTH(LN_DEPTH)) u_pixel_lines (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == S_PIX),
        .i_wr_addr (pix_wr_addr),
        .i_wr_data (r_pix),
        .i_rd_addr (pix_rd_addr),
        .o_rd_data (pix_rd_data)
    );

    hcd_ram #(.WIDTH(3 * PW), .DEPTH(LN_DEPTH)) u_product_lines (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == S_PWR),
        .i_wr_addr (prod_wr_addr),
        .i_wr_data (r_prod),
        .i_rd_addr (prod_rd_addr),
        .o_rd_data (prod_rd_data)
    );

    hcd_ram #(.WIDTH(64), .DEPTH(RS_DEPTH)) u_response_lines (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == S_RSP5),
        .i_wr_addr (resp_wr_addr),
        .i_wr_data (resp_wr_data),
        .i_rd_addr (resp_rd_addr),
        .o_rd_data (resp_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_row_cnt      <= '0;
            r_col_cnt      <= '0;
            r_cnt_s3       <= '0;
            r_cnt_s7       <= '0;
            r_i            <= '0;
            r_j            <= '0;
            r_iss_done     <= 1'b1;
            r_dv           <= 1'b0;
            r_out_valid    <= 1'b0;
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_k            <= RST_K_COEF;
            r_thr          <= RST_THRESHOLD;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    REG_FRAME_WIDTH:  r_frame_width  <= pwdata[11:0];
                    REG_FRAME_HEIGHT: r_frame_height <= pwdata[11:0];
                    REG_K_COEF:       r_k            <= pwdata[15:0];
                    REG_THRESHOLD:    r_thr          <= pwdata;
                    default:          ;
                endcase
            end
            if (r_state == S_PIX) begin
                r_col_cnt <= en_col[CW-1:0];
                r_row_cnt <= en_row[10:0];
                r_cnt_s3  <= en_s3;
                r_cnt_s7  <= en_s7;
            end
            // Each walk issues one read per cycle; the data comes back in the following cycle.
            if (r_state == S_PIX || r_state == S_PWR || r_state == S_CENW) begin
                r_i        <= '0;
                r_j        <= '0;
                r_iss_done <= 1'b0;
                r_dv       <= 1'b0;
            end else if (in_loop) begin
                r_dv <= !r_iss_done;
                if (!r_iss_done) begin
                    if (r_j == j_last) begin
                        r_j <= '0;
                        if (r_i == i_last) begin
                            r_iss_done <= 1'b1;
                        end else begin
                            r_i <= r_i + LW'(1);
                        end
                    end else begin
                        r_j <= r_j + LW'(1);
                    end
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign mxx   = r_gx * r_gx;
    assign myy   = r_gy * r_gy;
    assign mxy   = r_gx * r_gy;
    assign tr_sq = r_tr * r_tr;
    assign box_d = t_prod'(prod_rd_data);

    always_ff @(posedge i_clk) begin
        r_tag <= r_j[2:0];
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    r_pix <= i_in_data.pixel;
                    r_row <= st_row[10:0];
                    r_col <= st_col;
                    r_s3  <= st_s3;
                    r_s7  <= st_s7;
                end
            end
            S_PIX: begin
                // The newest tap is the pixel in hand, weighted +1 in both gradients.
                r_gx <= apply_weight(r_pix, W_POS1);
                r_gy <= apply_weight(r_pix, W_POS1);
            end
            S_GRD: begin
                if (r_dv) begin
                    r_gx <= r_gx + apply_weight(pix_rd_data, grad_wx(r_tag));
                    r_gy <= r_gy + apply_weight(pix_rd_data, grad_wy(r_tag));
                end
            end
            S_MUL: begin
                r_prod.pxx <= mxx[PW-1:0];
                r_prod.pyy <= myy[PW-1:0];
                r_prod.pxy <= mxy[PW-1:0];
            end
            S_PWR: begin
                r_sxx <= '0;
                r_syy <= '0;
                r_sxy <= '0;
            end
            S_BOX: begin
                if (r_dv) begin
                    r_sxx <= r_sxx + $signed({4'b0, box_d.pxx});
                    r_syy <= r_syy + $signed({4'b0, box_d.pyy});
                    r_sxy <= r_sxy + 26'(box_d.pxy);
                end
            end
            S_RSP1: begin
                r_m1 <= r_sxx * r_syy;
                r_m2 <= r_sxy * r_sxy;
                r_tr <= r_sxx + r_syy;
            end
            S_RSP2: begin
                r_det <= 64'(r_m1 - r_m2);
                r_t2  <= tr_sq[49:0];
            end
            S_RSP3: begin
                // k * trace^2 / 2^16 is split at bit 32 of trace^2 to keep each product narrow.
                r_khi <= r_k * r_t2[49:32];
                r_klo <= r_k * r_t2[31:0];
            end
            S_RSP4: begin
                r_kt <= 51'({r_khi, 16'h0000}) + 51'(r_klo[47:16]);
            end
            S_CENW: begin
                r_centre <= $signed(resp_rd_data);
                r_is_max <= 1'b1;
            end
            S_NMS: begin
                if (r_dv && ($signed(resp_rd_data) > r_centre)) begin
                    r_is_max <= 1'b0;
                end
            end
            default: ;
        endcase
        if (out_load) begin
            r_out_data.row       <= 11'(r_row - 11'(MARGIN));
            r_out_data.column    <= 11'(r_col - CW'(MARGIN));
            r_out_data.is_corner <= r_is_max && (r_centre > $signed({32'h0, r_thr}));
        end
    end

`ifndef NO_ASSERTIONS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_PIX))
        else $error("accepted pixel did not start processing");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && i_out_stall)
            |=> (r_state == S_OUT && $stable(o_out_data)))
        else $error("pending result overwritten while stalled");

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PIX && !cfg_wr) |=> ({1'b0, r_col_cnt} < eff_w))
        else $error("column counter left outside the frame width");

    a_result_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CEN) |-> ((32'(r_row) >= 2 * MARGIN) && (32'(r_col) >= 2 * MARGIN)))
        else $error("suppression started for a pixel too close to the edge");
`endif

endmodule
